>>> hw/rtl/bti_pkg.sv
// Shared constants and types for the breakpoint table interpolator.
package bti_pkg;

	localparam int MAX_ENTRIES = 32;
	localparam int FRAC_BITS   = 16;
	localparam int IDX_W       = $clog2(MAX_ENTRIES);
	localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
	localparam int FRAME_W     = 21;
	localparam int FACT_W      = 8 + FRAC_BITS;
	localparam int VAL_W       = 32;
	localparam int TGT_W       = FRAME_W + 1;
	localparam int MA_W        = FACT_W + 1;
	localparam int MB_W        = TGT_W + 1;
	localparam int DVD_W       = MA_W + MB_W;
	localparam int DVS_W       = TGT_W;

	localparam logic [FACT_W-1:0] ONE_FX = FACT_W'(1) << FRAC_BITS;
	localparam logic signed [FRAME_W-1:0] FRAME_MAX = {1'b0, {(FRAME_W-1){1'b1}}};
	localparam logic signed [FRAME_W-1:0] FRAME_MIN = {1'b1, {(FRAME_W-1){1'b0}}};

	localparam logic [2:0] OP_INIT   = 3'd0;
	localparam logic [2:0] OP_EVAL   = 3'd1;
	localparam logic [2:0] OP_ADD    = 3'd2;
	localparam logic [2:0] OP_OFFSET = 3'd3;
	localparam logic [2:0] OP_REMOVE = 3'd4;
	localparam logic [2:0] OP_SPEED  = 3'd5;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_EXISTS    = 3'd1;
	localparam logic [2:0] ST_PROTECTED = 3'd2;
	localparam logic [2:0] ST_FULL      = 3'd3;
	localparam logic [2:0] ST_RANGE     = 3'd4;

	localparam logic REG_LENGTH = 1'b0;
	localparam logic REG_START  = 1'b1;

	typedef logic [2:0] cell_op_t;
	localparam cell_op_t CELL_HOLD = 3'd0;
	localparam cell_op_t CELL_INIT = 3'd1;
	localparam cell_op_t CELL_INS  = 3'd2;
	localparam cell_op_t CELL_REM  = 3'd3;
	localparam cell_op_t CELL_OFF  = 3'd4;

	typedef struct packed {
		cell_op_t            op;
		logic [IDX_W-1:0]    idx;
		logic [CNT_W-1:0]    count;
		logic [FRAME_W-1:0]  frame_new;
		logic [FACT_W-1:0]   factor_new;
		logic [FRAME_W-1:0]  shift;
		logic [FRAME_W-1:0]  last_frame;
	} cell_ctl_t;

endpackage

>>> hw/rtl/bti_cell.sv
// One breakpoint cell: holds a frame and factor, shifts with its neighbors.
module bti_cell (
	input  logic                       clk,
	input  logic [bti_pkg::IDX_W-1:0]  my_idx,
	input  bti_pkg::cell_ctl_t         ctl,
	input  logic [bti_pkg::FRAME_W-1:0] prev_frame,
	input  logic [bti_pkg::FACT_W-1:0]  prev_factor,
	input  logic [bti_pkg::FRAME_W-1:0] next_frame,
	input  logic [bti_pkg::FACT_W-1:0]  next_factor,
	output logic [bti_pkg::FRAME_W-1:0] frame,
	output logic [bti_pkg::FACT_W-1:0]  factor
);
	import bti_pkg::*;

	logic [FRAME_W-1:0] frame_q;
	logic [FACT_W-1:0]  factor_q;
	logic signed [FRAME_W:0] sum;
	logic [FRAME_W-1:0] sat_sum;

	assign sum = $signed({frame_q[FRAME_W-1], frame_q}) +
		$signed({ctl.shift[FRAME_W-1], ctl.shift});

	always_comb begin
		if (sum > $signed({FRAME_MAX[FRAME_W-1], FRAME_MAX}))
			sat_sum = FRAME_MAX;
		else if (sum < $signed({FRAME_MIN[FRAME_W-1], FRAME_MIN}))
			sat_sum = FRAME_MIN;
		else
			sat_sum = sum[FRAME_W-1:0];
	end

	always_ff @(posedge clk) begin
		case (ctl.op)
			CELL_INIT: begin
				if (my_idx == IDX_W'(0)) begin
					frame_q  <= '0;
					factor_q <= '0;
				end else if (my_idx == IDX_W'(1)) begin
					frame_q  <= ctl.last_frame;
					factor_q <= ONE_FX;
				end
			end
			CELL_INS: begin
				if (my_idx > ctl.idx) begin
					frame_q  <= prev_frame;
					factor_q <= prev_factor;
				end else if (my_idx == ctl.idx) begin
					frame_q  <= ctl.frame_new;
					factor_q <= ctl.factor_new;
				end
			end
			CELL_REM: begin
				if (my_idx >= ctl.idx) begin
					frame_q  <= next_frame;
					factor_q <= next_factor;
				end
			end
			CELL_OFF: begin
				if (my_idx >= ctl.idx && {1'b0, my_idx} < ctl.count)
					frame_q <= sat_sum;
			end
			default: begin
			end
		endcase
	end

	assign frame  = frame_q;
	assign factor = factor_q;

endmodule

>>> hw/rtl/bti_div.sv
// Serial signed divider, one quotient bit per cycle, truncating toward zero.
module bti_div (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             go,
	input  logic signed [bti_pkg::DVD_W-1:0] dividend,
	input  logic signed [bti_pkg::DVS_W-1:0] divisor,
	output logic                             done,
	output logic signed [bti_pkg::DVD_W-1:0] quotient
);
	import bti_pkg::*;

	localparam int CW = $clog2(DVD_W + 1);

	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DVD_W-1:0] quo_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic             neg_q;
	logic [DVS_W:0]   sh;
	logic             fits;

	assign sh   = {rem_q, quo_q[DVD_W-1]};
	assign fits = sh >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			quo_q <= dividend[DVD_W-1] ? DVD_W'(-dividend) : DVD_W'(dividend);
			dvs_q <= divisor[DVS_W-1] ? DVS_W'(-divisor) : DVS_W'(divisor);
			neg_q <= dividend[DVD_W-1] ^ divisor[DVS_W-1];
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? DVS_W'(sh - {1'b0, dvs_q}) : sh[DVS_W-1:0];
			quo_q <= {quo_q[DVD_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? -$signed(quo_q) : $signed(quo_q);

endmodule

>>> hw/rtl/breakpoint_table_interpolator.sv
// Top level: command sequencer over a chain of breakpoint cells and a serial divider.
//
// Usage: drive operation, frame, entry_index and shift_amount with start high
// while busy is low; that edge accepts the transaction. Exactly one result
// follows, shown on status, value, new_index and entry_count for one cycle
// with done high. The receiver cannot stall; done is a single-cycle strobe.
// Configuration (wr_en, wr_index, wr_data) writes content_length (index 0)
// or strip_start (index 1) at once, and is meant only while the block is idle.
// Init, offset, remove and bad opcodes finish at the accepting edge, as do
// speed requests out of range or at entry 0. Evaluate and add walk the cell
// chain one entry per cycle, then, for a segment of positive length, do one
// multiply and a serial divide. Speed takes two multiplies and the divide.
// Insert, remove and offset update the affected cells in parallel. Busy stays
// high for the whole of any command that leaves idle.
// Reset empties the table (count 0) and loads content_length 1, strip_start 0.
module breakpoint_table_interpolator (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [2:0]                        operation,
	input  logic signed [bti_pkg::FRAME_W-1:0] frame,
	input  logic [4:0]                        entry_index,
	input  logic signed [bti_pkg::FRAME_W-1:0] shift_amount,
	input  logic                              wr_en,
	input  logic                              wr_index,
	input  logic [20:0]                       wr_data,
	output logic                              done,
	output logic [2:0]                        status,
	output logic signed [31:0]                value,
	output logic [4:0]                        new_index,
	output logic [5:0]                        entry_count
);
	import bti_pkg::*;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_SCAN = 4'd1;
	localparam logic [3:0] S_CHK  = 4'd2;
	localparam logic [3:0] S_MUL  = 4'd3;
	localparam logic [3:0] S_IDIV = 4'd4;
	localparam logic [3:0] S_DIVW = 4'd5;
	localparam logic [3:0] S_FIN  = 4'd6;
	localparam logic [3:0] S_MULA = 4'd7;
	localparam logic [3:0] S_RP   = 4'd8;
	localparam logic [3:0] S_MULB = 4'd9;
	localparam logic [3:0] S_SPD  = 4'd10;

	logic [3:0]              state_q;
	logic [2:0]              op_q;
	logic signed [TGT_W-1:0] target_q;
	logic [IDX_W-1:0]        k_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [CNT_W-1:0]        i_q;
	logic [IDX_W-1:0]        p_q;
	logic                    found_q;
	logic signed [MA_W-1:0]  mula_q;
	logic signed [MB_W-1:0]  mulb_q;
	logic signed [DVD_W-1:0] prod_q;
	logic signed [VAL_W-1:0] rp_q;
	logic [FACT_W-1:0]       base_q;
	logic signed [DVS_W-1:0] dl_q;
	logic [FACT_W-1:0]       v_q;
	logic [FRAME_W-1:0]      len_q;
	logic [FRAME_W-1:0]      strip_q;
	logic                    done_q;
	logic [2:0]              status_q;
	logic signed [VAL_W-1:0] value_q;
	logic [IDX_W-1:0]        nidx_q;

	logic [FRAME_W-1:0] frame_w [MAX_ENTRIES];
	logic [FACT_W-1:0]  fact_w  [MAX_ENTRIES];
	cell_ctl_t          ctl;

	genvar g;
	generate
		for (g = 0; g < MAX_ENTRIES; g++) begin : g_cell
			bti_cell u_cell (
				.clk         (clk),
				.my_idx      (IDX_W'(g)),
				.ctl         (ctl),
				.prev_frame  (frame_w[(g == 0) ? 0 : g - 1]),
				.prev_factor (fact_w[(g == 0) ? 0 : g - 1]),
				.next_frame  (frame_w[(g == MAX_ENTRIES - 1) ? g : g + 1]),
				.next_factor (fact_w[(g == MAX_ENTRIES - 1) ? g : g + 1]),
				.frame       (frame_w[g]),
				.factor      (fact_w[g])
			);
		end
	endgenerate

	// Command decode helpers
	logic                    acc;
	logic [IDX_W-1:0]        scan_idx;
	logic                    scan_end;
	logic [IDX_W-1:0]        p_nx;
	logic [IDX_W-1:0]        k_pv;
	logic                    p_last;
	logic signed [TGT_W-1:0] fp;
	logic signed [TGT_W-1:0] fn;
	logic signed [TGT_W-1:0] len_d;
	logic signed [MA_W-1:0]  dfac;
	logic signed [MB_W-1:0]  didx;
	logic signed [TGT_W-1:0] m_val;
	logic signed [TGT_W-1:0] lf22;
	logic [FRAME_W-1:0]      last_frame;
	logic signed [DVD_W-1:0] rnd;
	logic signed [VAL_W-1:0] rc;
	logic signed [VAL_W-1:0] rdiff;
	logic signed [TGT_W-1:0] dl_spd;
	logic                    div_go;
	logic signed [DVD_W-1:0] dvd_c;
	logic signed [DVS_W-1:0] dvs_c;
	logic                    div_done;
	logic signed [DVD_W-1:0] quo;
	logic signed [MA_W-1:0]  vsum;
	logic                    q_hi;
	logic                    q_lo;
	logic [CNT_W-1:0]        k_ext;

	assign acc      = start && (state_q == S_IDLE);
	assign scan_idx = i_q[IDX_W-1:0];
	assign scan_end = (i_q == cnt_q) ||
		($signed({frame_w[scan_idx][FRAME_W-1], frame_w[scan_idx]}) > target_q);
	assign p_nx     = p_q + 1'b1;
	assign k_pv     = k_q - 1'b1;
	assign p_last   = (CNT_W'(p_q) + 1'b1) >= cnt_q;
	assign fp       = $signed({frame_w[p_q][FRAME_W-1], frame_w[p_q]});
	assign fn       = $signed({frame_w[p_nx][FRAME_W-1], frame_w[p_nx]});
	assign len_d    = fn - fp;
	assign dfac     = $signed({1'b0, fact_w[p_nx]}) - $signed({1'b0, fact_w[p_q]});
	assign didx     = $signed({target_q[TGT_W-1], target_q}) - $signed({fp[TGT_W-1], fp});
	assign m_val    = $signed({1'b0, len_q}) - TGT_W'(1);
	assign lf22     = $signed({1'b0, len_q}) - TGT_W'(1);
	assign last_frame = (lf22 > $signed({FRAME_MAX[FRAME_W-1], FRAME_MAX})) ? FRAME_MAX :
		lf22[FRAME_W-1:0];
	assign rnd      = prod_q + (DVD_W'(1) <<< (FRAC_BITS - 1));
	assign rc       = VAL_W'(rnd >>> FRAC_BITS);
	assign rdiff    = rc - rp_q;
	assign dl_spd   = $signed({frame_w[k_q][FRAME_W-1], frame_w[k_q]}) -
		$signed({frame_w[k_pv][FRAME_W-1], frame_w[k_pv]});
	assign div_go   = (state_q == S_IDIV) || (state_q == S_SPD && dl_spd != '0);
	assign dvd_c    = (state_q == S_SPD) ? ($signed(DVD_W'(rdiff)) <<< FRAC_BITS) : prod_q;
	assign dvs_c    = (state_q == S_SPD) ? dl_spd : dl_q;
	assign vsum     = $signed({1'b0, base_q}) + quo[MA_W-1:0];
	assign q_hi     = !quo[DVD_W-1] && (quo[DVD_W-2:VAL_W-1] != '0);
	assign q_lo     = quo[DVD_W-1] && (quo[DVD_W-2:VAL_W-1] != '1);
	assign k_ext    = CNT_W'(entry_index);

	bti_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (div_go),
		.dividend (dvd_c),
		.divisor  (dvs_c),
		.done     (div_done),
		.quotient (quo)
	);

	always_comb begin
		ctl            = '0;
		ctl.op         = CELL_HOLD;
		ctl.count      = cnt_q;
		ctl.shift      = shift_amount;
		ctl.last_frame = last_frame;
		ctl.frame_new  = target_q[FRAME_W-1:0];
		ctl.factor_new = v_q;
		ctl.idx        = entry_index;
		if (acc) begin
			case (operation)
				OP_INIT:   ctl.op = CELL_INIT;
				OP_OFFSET: if (k_ext < cnt_q && entry_index != '0) ctl.op = CELL_OFF;
				OP_REMOVE: if (k_ext < cnt_q && entry_index != '0 &&
					k_ext + 1'b1 != cnt_q) ctl.op = CELL_REM;
				default: ctl.op = CELL_HOLD;
			endcase
		end else if (state_q == S_FIN && op_q == OP_ADD) begin
			ctl.op  = CELL_INS;
			ctl.idx = p_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cnt_q    <= '0;
			done_q   <= 1'b0;
			len_q    <= FRAME_W'(1);
			strip_q  <= '0;
			status_q <= ST_OK;
			value_q  <= '0;
			nidx_q   <= '0;
			v_q      <= '0;
		end else begin
			done_q <= 1'b0;
			if (wr_en) begin
				case (wr_index)
					REG_LENGTH: len_q   <= wr_data;
					REG_START:  strip_q <= wr_data;
					default: ;
				endcase
			end
			case (state_q)
				S_IDLE: if (start) begin
					status_q <= ST_OK;
					value_q  <= '0;
					nidx_q   <= '0;
					case (operation)
						OP_INIT: begin
							cnt_q  <= CNT_W'(2);
							done_q <= 1'b1;
						end
						OP_EVAL, OP_ADD: state_q <= S_SCAN;
						OP_OFFSET: begin
							done_q <= 1'b1;
							if (k_ext >= cnt_q) status_q <= ST_RANGE;
							else if (entry_index == '0) status_q <= ST_PROTECTED;
						end
						OP_REMOVE: begin
							done_q <= 1'b1;
							if (k_ext >= cnt_q) status_q <= ST_RANGE;
							else if (entry_index == '0 || k_ext + 1'b1 == cnt_q)
								status_q <= ST_PROTECTED;
							else cnt_q <= cnt_q - 1'b1;
						end
						OP_SPEED: begin
							if (k_ext >= cnt_q) begin
								status_q <= ST_RANGE;
								done_q   <= 1'b1;
							end else if (entry_index == '0) begin
								value_q <= VAL_W'(ONE_FX);
								done_q  <= 1'b1;
							end else state_q <= S_MULA;
						end
						default: begin
							status_q <= ST_RANGE;
							done_q   <= 1'b1;
						end
					endcase
				end
				S_SCAN: if (scan_end) state_q <= S_CHK;
				S_CHK: begin
					if (!found_q) begin
						status_q <= ST_RANGE;
						done_q   <= 1'b1;
						state_q  <= S_IDLE;
					end else if (op_q == OP_ADD && fp == target_q) begin
						status_q <= ST_EXISTS;
						done_q   <= 1'b1;
						state_q  <= S_IDLE;
					end else if (p_last) begin
						if (op_q == OP_ADD) status_q <= ST_RANGE;
						else value_q <= VAL_W'(ONE_FX);
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else if (op_q == OP_ADD && cnt_q >= CNT_W'(MAX_ENTRIES)) begin
						status_q <= ST_FULL;
						done_q   <= 1'b1;
						state_q  <= S_IDLE;
					end else if (len_d <= 0) begin
						v_q     <= fact_w[p_q];
						state_q <= S_FIN;
					end else state_q <= S_MUL;
				end
				S_MUL:  state_q <= S_IDIV;
				S_IDIV: state_q <= S_DIVW;
				S_DIVW: if (div_done) begin
					if (op_q == OP_SPEED) begin
						value_q <= q_hi ? {1'b0, {(VAL_W-1){1'b1}}} :
							q_lo ? {1'b1, {(VAL_W-1){1'b0}}} : quo[VAL_W-1:0];
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						v_q     <= vsum[FACT_W-1:0];
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					value_q <= VAL_W'(v_q);
					done_q  <= 1'b1;
					state_q <= S_IDLE;
					if (op_q == OP_ADD) begin
						nidx_q <= p_nx;
						cnt_q  <= cnt_q + 1'b1;
					end
				end
				S_MULA: state_q <= S_RP;
				S_RP:   state_q <= S_MULB;
				S_MULB: state_q <= S_SPD;
				S_SPD: begin
					if (dl_spd == '0) begin
						status_q <= ST_RANGE;
						done_q   <= 1'b1;
						state_q  <= S_IDLE;
					end else state_q <= S_DIVW;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers, no reset needed
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				op_q    <= operation;
				k_q     <= entry_index;
				i_q     <= '0;
				found_q <= 1'b0;
				p_q     <= '0;
				if (operation == OP_ADD)
					target_q <= $signed({frame[FRAME_W-1], frame}) -
						$signed({strip_q[FRAME_W-1], strip_q});
				else
					target_q <= $signed({frame[FRAME_W-1], frame});
			end
			S_SCAN: if (!scan_end) begin
				p_q     <= scan_idx;
				found_q <= 1'b1;
				i_q     <= i_q + 1'b1;
			end
			S_CHK: begin
				base_q <= fact_w[p_q];
				mula_q <= dfac;
				mulb_q <= didx;
				dl_q   <= len_d;
			end
			S_MUL, S_MULB: prod_q <= mula_q * mulb_q;
			S_MULA: begin
				mula_q <= $signed({1'b0, fact_w[k_pv]});
				mulb_q <= $signed({m_val[TGT_W-1], m_val});
			end
			S_RP: begin
				rp_q   <= rc;
				mula_q <= $signed({1'b0, fact_w[k_q]});
			end
			default: ;
		endcase
		if (state_q == S_MULA) prod_q <= $signed({1'b0, fact_w[k_pv]}) *
			$signed({m_val[TGT_W-1], m_val});
	end

	assign busy        = state_q != S_IDLE;
	assign done        = done_q;
	assign status      = status_q;
	assign value       = value_q;
	assign new_index   = nidx_q;
	assign entry_count = cnt_q;

`ifndef SYNTHESIS
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result shown while busy");
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != ST_OK) |-> (value == '0 && new_index == '0))
		else $error("error result carries data");
	a_cnt_max: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_ENTRIES)) else $error("entry count overflow");
	a_div_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == S_DIVW) else $error("divide finished unexpectedly");
`endif

endmodule
